// ===== rtl/rvm_pkg.sv =====
// Package for the relativistic velocity block: item types, sideband types and constants.
// Used by every module of the block; depends on nothing.
package rvm_pkg;

  // Input item: one particle.
  typedef struct packed {
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic        [31:0] particle_mass;
  } rvm_in_t;

  // Result item: velocity, Lorentz factor and error flag.
  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic        [31:0] lorentz_factor;
    logic               error_flag;
  } rvm_out_t;

  // Values that ride along the square root pipeline.
  typedef struct packed {
    logic        err;
    logic [2:0]  neg;
    logic [63:0] mc;
    logic [63:0] pc_x;
    logic [63:0] pc_y;
    logic [63:0] pc_z;
  } rvm_side_t;

  // Flags that ride along the divider pipelines.
  typedef struct packed {
    logic       err;
    logic [2:0] neg;
  } rvm_flags_t;

  localparam int unsigned QUOT_W  = 32;
  localparam int unsigned DIV_LAT = QUOT_W + 1;

  localparam logic [31:0] LIGHT_RESET = 32'h0001_0000;
  localparam logic [31:0] VEL_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] VEL_MIN     = 32'h8000_0000;
  localparam logic [31:0] GAMMA_MAX   = 32'hFFFF_FFFF;

endpackage

// ===== rtl/rvm_front.sv =====
// Front end: magnitudes, products and the radicand (|p|^2 2^2F + (mc)^2) 2^2F.
// Four register stages. Depends on rvm_pkg.
module rvm_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  rvm_pkg::rvm_in_t       item_i,
  input  logic [31:0]            light_i,
  output logic                   valid_o,
  output logic [((64 + 2*FRAC_BITS) > 128 ? 64 + 2*FRAC_BITS : 128) + 1 + 2*FRAC_BITS - 1:0]
                                 radicand_o,
  output rvm_pkg::rvm_side_t     side_o
);
  import rvm_pkg::*;

  localparam int unsigned SHIFT = 2 * FRAC_BITS;
  localparam int unsigned S_W   = ((64 + SHIFT) > 128 ? 64 + SHIFT : 128) + 1;
  localparam int unsigned RAD_W = S_W + SHIFT;

  logic [31:0] comp_in [3];

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [31:0] mag_q [3];
  logic [2:0]  neg1_q, neg2_q, neg3_q;
  logic [31:0] mass_q, light_q;
  logic        err1_q, err2_q, err3_q;
  logic [63:0] sq_q [3];
  logic [63:0] pc2_q [3];
  logic [63:0] pc3_q [3];
  logic [63:0] mc2_q, mc3_q;
  logic [63:0] psum_q, mc_hh_q, mc_hl_q, mc_ll_q;
  logic [RAD_W-1:0] rad_q;
  rvm_side_t   side_q;
  logic [S_W-1:0] sum_d;

  assign comp_in[0] = item_i.momentum_x;
  assign comp_in[1] = item_i.momentum_y;
  assign comp_in[2] = item_i.momentum_z;

  // Valid bits of the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: sign and magnitude of each axis, error check.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg1_q[i] <= comp_in[i][31];
      mag_q[i]  <= comp_in[i][31] ? (~comp_in[i] + 32'd1) : comp_in[i];
    end
    mass_q  <= item_i.particle_mass;
    light_q <= light_i;
    err1_q  <= (item_i.particle_mass == '0) || (light_i == '0);
  end

  // Stage 2: squares, m*c and p*c per axis.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i]  <= mag_q[i] * mag_q[i];
      pc2_q[i] <= mag_q[i] * light_q;
    end
    mc2_q  <= mass_q * light_q;
    neg2_q <= neg1_q;
    err2_q <= err1_q;
  end

  // Stage 3: sum of squares and partial products of (mc)^2.
  always_ff @(posedge clk_i) begin
    psum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
    mc_hh_q <= mc2_q[63:32] * mc2_q[63:32];
    mc_hl_q <= mc2_q[63:32] * mc2_q[31:0];
    mc_ll_q <= mc2_q[31:0] * mc2_q[31:0];
    for (int i = 0; i < 3; i++) begin
      pc3_q[i] <= pc2_q[i];
    end
    mc3_q  <= mc2_q;
    neg3_q <= neg2_q;
    err3_q <= err2_q;
  end

  // Stage 4: the sum under the root.
  assign sum_d = (S_W'(psum_q) << SHIFT) + (S_W'(mc_hh_q) << 64)
               + (S_W'(mc_hl_q) << 33) + S_W'(mc_ll_q);

  always_ff @(posedge clk_i) begin
    rad_q       <= {sum_d, {SHIFT{1'b0}}};
    side_q.err  <= err3_q;
    side_q.neg  <= neg3_q;
    side_q.mc   <= mc3_q;
    side_q.pc_x <= pc3_q[0];
    side_q.pc_y <= pc3_q[1];
    side_q.pc_z <= pc3_q[2];
  end

  assign valid_o    = v4_q;
  assign radicand_o = rad_q;
  assign side_o     = side_q;

endmodule

// ===== rtl/rvm_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries the particle sideband alongside. Depends on rvm_pkg.
module rvm_sqrt #(
  parameter int unsigned RAD_W = 161
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [RAD_W-1:0]         radicand_i,
  input  rvm_pkg::rvm_side_t       side_i,
  output logic                     valid_o,
  output logic [(RAD_W+1)/2-1:0]   root_o,
  output rvm_pkg::rvm_side_t       side_o
);
  import rvm_pkg::*;

  localparam int unsigned ROOT_W = (RAD_W + 1) / 2;
  localparam int unsigned PAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic [PAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic              vld_q  [ROOT_W];
  rvm_side_t         side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [PAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              vld_in;
    rvm_side_t         side_in;
    logic [REM_W:0]    t;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = PAD_W'(radicand_i);
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      t     = {rem_in[REM_W-2:0], rad_in[PAD_W-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      diff  = t - trial;
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in << 2;
      rem_q[k]  <= ge ? REM_W'(diff) : REM_W'(t);
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

// ===== rtl/rvm_div.sv =====
// Pipelined restoring divider with a 32 bit quotient and an overflow flag.
// One check stage, then one quotient bit per register stage. Depends on rvm_pkg.
module rvm_div #(
  parameter int unsigned N_W = 96,
  parameter int unsigned D_W = 81
) (
  input  logic                      clk_i,
  input  logic [N_W-1:0]            num_i,
  input  logic [D_W-1:0]            den_i,
  output logic [rvm_pkg::QUOT_W-1:0] quot_o,
  output logic                      ovf_o
);
  import rvm_pkg::*;

  localparam int unsigned HI_W = N_W - QUOT_W;
  localparam int unsigned CW   = (HI_W > D_W) ? HI_W : D_W;

  logic [CW-1:0]     hi_ext;
  logic [CW-1:0]     den_ext;

  logic [D_W-1:0]    rem_q  [DIV_LAT];
  logic [QUOT_W-1:0] low_q  [DIV_LAT];
  logic [QUOT_W-1:0] quot_q [DIV_LAT];
  logic [D_W-1:0]    den_q  [DIV_LAT];
  logic              ovf_q  [DIV_LAT];

  assign hi_ext  = CW'(num_i[N_W-1:QUOT_W]);
  assign den_ext = CW'(den_i);

  // Check stage: a quotient of 2^32 or more only needs the overflow flag.
  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= (hi_ext >= den_ext);
    rem_q[0]  <= D_W'(hi_ext);
    low_q[0]  <= num_i[QUOT_W-1:0];
    quot_q[0] <= '0;
    den_q[0]  <= den_i;
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
    logic [D_W:0] t;
    logic [D_W:0] diff;
    logic         ge;

    // Shift in the next numerator bit and subtract when it fits.
    always_comb begin
      t    = {rem_q[j-1], low_q[j-1][QUOT_W-1]};
      diff = t - {1'b0, den_q[j-1]};
      ge   = (t >= {1'b0, den_q[j-1]});
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= ge ? D_W'(diff) : D_W'(t);
      low_q[j]  <= low_q[j-1] << 1;
      quot_q[j] <= {quot_q[j-1][QUOT_W-2:0], ge};
      den_q[j]  <= den_q[j-1];
      ovf_q[j]  <= ovf_q[j-1];
    end
  end

  assign quot_o = quot_q[DIV_LAT-1];
  assign ovf_o  = ovf_q[DIV_LAT-1];

endmodule

// ===== rtl/relativistic_velocity_from_momentum.sv =====
// Relativistic velocity and Lorentz factor from momentum, fully pipelined.
// Top level; depends on rvm_pkg, rvm_front, rvm_sqrt and rvm_div.
//
// Usage:
//   A particle item (item_i) is taken at a rising edge where start_i is high
//   and busy_o is low. busy_o is always low: one item can enter every cycle.
//   Each result appears on result_o for exactly one cycle with done_o high,
//   in the order the items were taken; the receiver cannot stall it.
//   The speed of light is written over cfg_valid_i / cfg_data_i; cfg_ready_o
//   is always high. Write it only while no item is in flight.
// Pipeline:
//   4 front stages + ROOT_W root stages + 33 divider stages + 1 output stage,
//   with ROOT_W = (2*FRAC_BITS + 130) / 2.
//   The square root, one result bit per stage, sets the depth.
// Throughput: one item per cycle.
// Reset: clears all valid bits and sets the speed of light to 1.0 (0x10000);
//   items in flight are dropped.
module relativistic_velocity_from_momentum #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rvm_pkg::rvm_in_t  item_i,
  output logic              done_o,
  output rvm_pkg::rvm_out_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);
  import rvm_pkg::*;

  localparam int unsigned SHIFT  = 2 * FRAC_BITS;
  localparam int unsigned S_W    = ((64 + SHIFT) > 128 ? 64 + SHIFT : 128) + 1;
  localparam int unsigned RAD_W  = S_W + SHIFT;
  localparam int unsigned ROOT_W = (RAD_W + 1) / 2;
  localparam int unsigned NUM_W  = 64 + SHIFT;
  localparam int unsigned LAT    = 4 + ROOT_W + DIV_LAT + 1;

  logic [31:0]       light_q;
  logic              front_vld;
  logic [RAD_W-1:0]  radicand;
  rvm_side_t         front_side;
  logic              root_vld;
  logic [ROOT_W-1:0] root;
  rvm_side_t         root_side;
  logic [QUOT_W-1:0] quot [4];
  logic              ovf  [4];
  logic              dv_q [DIV_LAT];
  rvm_flags_t        fl_q [DIV_LAT];
  logic              done_q;
  rvm_out_t          out_q;
  rvm_out_t          out_d;
  logic [31:0]       vel  [3];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Speed of light register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= LIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      light_q <= cfg_data_i;
    end
  end

  rvm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i && !busy_o),
    .item_i     (item_i),
    .light_i    (light_q),
    .valid_o    (front_vld),
    .radicand_o (radicand),
    .side_o     (front_side)
  );

  rvm_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_vld),
    .radicand_i (radicand),
    .side_i     (front_side),
    .valid_o    (root_vld),
    .root_o     (root),
    .side_o     (root_side)
  );

  rvm_div #(.N_W(NUM_W), .D_W(ROOT_W)) u_div_x (
    .clk_i (clk_i),
    .num_i ({root_side.pc_x, {SHIFT{1'b0}}}),
    .den_i (root),
    .quot_o(quot[0]),
    .ovf_o (ovf[0])
  );

  rvm_div #(.N_W(NUM_W), .D_W(ROOT_W)) u_div_y (
    .clk_i (clk_i),
    .num_i ({root_side.pc_y, {SHIFT{1'b0}}}),
    .den_i (root),
    .quot_o(quot[1]),
    .ovf_o (ovf[1])
  );

  rvm_div #(.N_W(NUM_W), .D_W(ROOT_W)) u_div_z (
    .clk_i (clk_i),
    .num_i ({root_side.pc_z, {SHIFT{1'b0}}}),
    .den_i (root),
    .quot_o(quot[2]),
    .ovf_o (ovf[2])
  );

  rvm_div #(.N_W(ROOT_W), .D_W(64)) u_div_g (
    .clk_i (clk_i),
    .num_i (root),
    .den_i (root_side.mc),
    .quot_o(quot[3]),
    .ovf_o (ovf[3])
  );

  // Valid bits and flags follow the dividers stage by stage.
  for (genvar j = 0; j < DIV_LAT; j++) begin : g_flags
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else begin
        dv_q[j] <= (j == 0) ? root_vld : dv_q[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (j == 0) begin
        fl_q[j] <= '{err: root_side.err, neg: root_side.neg};
      end else begin
        fl_q[j] <= fl_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Saturate, apply signs and force zeros on error.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fl_q[DIV_LAT-1].neg[i]) begin
        vel[i] = (ovf[i] || quot[i][31]) ? VEL_MIN : (~quot[i] + 32'd1);
      end else begin
        vel[i] = (ovf[i] || quot[i][31]) ? VEL_MAX : quot[i];
      end
    end
    out_d = '0;
    out_d.error_flag = fl_q[DIV_LAT-1].err;
    if (!fl_q[DIV_LAT-1].err) begin
      out_d.velocity_x     = vel[0];
      out_d.velocity_y     = vel[1];
      out_d.velocity_z     = vel[2];
      out_d.lorentz_factor = ovf[3] ? GAMMA_MAX : quot[3];
    end
  end

  // Output register and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

  // Every accepted item comes out after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("item did not complete after the pipeline latency");

  // A valid Lorentz factor is never below one.
  a_gamma_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.error_flag) |-> (result_o.lorentz_factor >= (32'd1 << FRAC_BITS)))
    else $error("Lorentz factor below one");

  // An error result carries zeros.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.error_flag) |->
      (result_o.velocity_x == '0 && result_o.velocity_y == '0 &&
       result_o.velocity_z == '0 && result_o.lorentz_factor == '0))
    else $error("error result with nonzero fields");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for relativistic_velocity_from_momentum.
// Depends on rvm_pkg and the block's RTL. A scoreboard class predicts the velocity and
// the Lorentz factor in wide integer arithmetic. Several speed-of-light settings are used.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rvm_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned DRAIN_CYCLES = 140;
  localparam int unsigned STALL_LIMIT = 4000;

  // Predicts results in wide integers and checks them in order.
  class velocity_scoreboard;
    rvm_out_t expected_q[$];
    logic [31:0] light;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned errors_seen;

    function new();
      light = LIGHT_RESET;
      mismatches = 0;
      checked = 0;
      errors_seen = 0;
    endfunction

    // Bitwise integer square root, floor of the exact root.
    function automatic logic [191:0] isqrt(logic [191:0] n);
      logic [191:0] root;
      logic [191:0] bitv;
      root = '0;
      bitv = 192'd1 << 190;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // Works out the expected result for one accepted particle.
    function void note_item(rvm_in_t p);
      rvm_out_t r;
      logic [31:0] comp [3];
      logic [63:0] mag [3];
      logic neg [3];
      logic [191:0] psum, mc, s, root, q;
      psum = '0;
      comp[0] = p.momentum_x;
      comp[1] = p.momentum_y;
      comp[2] = p.momentum_z;
      for (int i = 0; i < 3; i++) begin
        neg[i] = comp[i][31];
        mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, comp[i]}) : {32'd0, comp[i]};
        psum = psum + mag[i] * mag[i];
      end
      r = '0;
      if (p.particle_mass == 0 || light == 0) begin
        r.error_flag = 1'b1;
        errors_seen++;
      end else begin
        mc = {160'd0, p.particle_mass} * {160'd0, light};
        s = (psum << (2 * FRAC)) + mc * mc;
        root = isqrt(s << (2 * FRAC));
        for (int i = 0; i < 3; i++) begin
          q = (({128'd0, mag[i]} * {160'd0, light}) << (2 * FRAC)) / root;
          if (neg[i]) comp[i] = (q >= 192'h8000_0000) ? VEL_MIN : -q[31:0];
          else comp[i] = (q > 192'h7FFF_FFFF) ? VEL_MAX : q[31:0];
        end
        r.velocity_x = comp[0];
        r.velocity_y = comp[1];
        r.velocity_z = comp[2];
        q = root / mc;
        r.lorentz_factor = (q > 192'hFFFF_FFFF) ? GAMMA_MAX : q[31:0];
      end
      expected_q.push_back(r);
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(rvm_out_t got);
      rvm_out_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.velocity_x !== exp_r.velocity_x || got.velocity_y !== exp_r.velocity_y ||
          got.velocity_z !== exp_r.velocity_z ||
          got.lorentz_factor !== exp_r.lorentz_factor ||
          got.error_flag !== exp_r.error_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: vx %h/%h vy %h/%h vz %h/%h gamma %h/%h err %b/%b (exp/act)",
                   exp_r.velocity_x, got.velocity_x, exp_r.velocity_y, got.velocity_y,
                   exp_r.velocity_z, got.velocity_z, exp_r.lorentz_factor,
                   got.lorentz_factor, exp_r.error_flag, got.error_flag);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  rvm_in_t item_i = '0;
  logic done_o;
  rvm_out_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  velocity_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;

  relativistic_velocity_from_momentum #(.FRAC_BITS(FRAC)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .done_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Observes accepted items, configuration writes and results; runs the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start_i && !busy_o) begin
        sb.note_item(item_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.light = cfg_data_i;
      end
      if (done_o) begin
        sb.check_result(result_o);
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog timeout");
        $display("** relativistic_velocity_from_momentum: FAILED **");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones, and many back-to-back items.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random value with a random magnitude range so that small values are common.
  function automatic logic [31:0] rand_word();
    logic [31:0] v;
    v = $urandom() >> $urandom_range(0, 31);
    if ($urandom_range(0, 3) == 0) v = $urandom();
    return v;
  endfunction

  function automatic logic [31:0] rand_momentum();
    logic [31:0] v;
    v = rand_word();
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Presents one item and holds it until accepted.
  task automatic send_item(rvm_in_t p);
    int unsigned gap;
    start_i <= 1'b1;
    item_i <= p;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] m);
    rvm_in_t p;
    p.momentum_x = px;
    p.momentum_y = py;
    p.momentum_z = pz;
    p.particle_mass = m;
    send_item(p);
  endtask

  // Waits until the pipeline is empty.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the speed of light; called only with the block idle.
  task automatic write_light(logic [31:0] c);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_particle(rand_momentum(), rand_momentum(), rand_momentum(),
                    ($urandom_range(0, 19) == 0) ? 32'd0 : rand_word());
  endtask

  logic [31:0] light_settings [5] = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 32'd0,
                                      32'h0003_0000};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rest particle, extreme momenta, zero and largest mass.
    send_particle(32'd0, 32'd0, 32'd0, 32'h0001_0000);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h0001_0000);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_particle(32'h0001_0000, 32'hFFFF_0000, 32'd1, 32'd0);
    send_particle(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_particle(32'h0000_8000, 32'd0, 32'd0, 32'h0001_0000);
    send_particle(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_particle(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h5555_5555);
    send_particle(32'd0, 32'd0, 32'd0, 32'd0);

    // Random items under each speed-of-light setting, extremes included.
    foreach (light_settings[k]) begin
      drain();
      write_light(light_settings[k]);
      send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 32'd1);
      random_phase(78);
    end
    drain();

    $display("Sent %0d particles over %0d light settings; %0d results checked, %0d errors.",
             items_sent, $size(light_settings), sb.checked, sb.errors_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** relativistic_velocity_from_momentum: PASSED **");
    end else begin
      $display("** relativistic_velocity_from_momentum: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rvm_pkg.sv
rtl/rvm_front.sv
rtl/rvm_sqrt.sv
rtl/rvm_div.sv
rtl/relativistic_velocity_from_momentum.sv
tb/tb_top.sv
